/* rtl/core/icr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package icr_pkg;

   // Width of the root field on the result channel.
   localparam int ROOT_W = 11;

   // Result tdata is the root field padded to whole bytes.
   localparam int RSP_TDATA_W = ((ROOT_W + 7) / 8) * 8;

endpackage : icr_pkg

`default_nettype wire

/* rtl/core/icr_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One root bit of the restoring cube root.
// Tracks root r and its square s so the trial 3a^2+3a+1 with a = 2r
// becomes 12s + 6r + 1: shifts and adds only, no multiplier.
module icr_cell #(
   parameter int RB  = 32,   // radicand width
   parameter int RW  = 11,   // root width
   parameter int POS = 0     // radicand bit where this cell's group starts
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   output      logic              up_ready,
   input  wire logic [RB-1:0]     up_rem,
   input  wire logic [RW-1:0]     up_root,
   input  wire logic [2*RW-1:0]   up_sq,
   output      logic              dn_valid,
   input  wire logic              dn_ready,
   output      logic [RB-1:0]     dn_rem,
   output      logic [RW-1:0]     dn_root,
   output      logic [2*RW-1:0]   dn_sq
);

   localparam int SW = 2 * RW;
   localparam int CW = (RB > SW + 4) ? RB : SW + 4;

   logic            valid_ff, valid_in;
   logic [RB-1:0]   rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [SW-1:0]   sq_ff, sq_in;

   logic [CW-1:0]   trial;
   logic [CW-1:0]   rem_hi;
   logic [RB-1:0]   trial_sh;
   logic            fits;
   logic            load;

   assign trial = (CW'(up_sq) << 3) + (CW'(up_sq) << 2)
                + (CW'(up_root) << 2) + (CW'(up_root) << 1) + CW'(1);
   assign rem_hi   = CW'(up_rem >> POS);
   assign fits     = rem_hi >= trial;
   // exact whenever the trial fits, which is the only time it is used
   assign trial_sh = RB'(trial << POS);

   assign rem_in  = fits ? up_rem - trial_sh : up_rem;
   assign root_in = {up_root[RW-2:0], fits};
   // (2r+b)^2 = 4s + b*(4r+1)
   assign sq_in   = (up_sq << 2) + (fits ? ((SW'(up_root) << 2) + SW'(1)) : '0);

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         sq_ff   <= sq_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_sq    = sq_ff;

endmodule : icr_cell

`default_nettype wire

/* rtl/core/integer_cube_root.sv */
`timescale 1ns / 1ps
`default_nettype none

// Integer cube root, rounded down. Each item on the req_ channel carries an
// unsigned radicand; the matching item on the rsp_ channel carries the
// largest integer whose cube does not exceed it. The work runs through a row
// of RADICAND_BITS/3 + 1 cells (eleven at the default 32 bits), one per root
// bit, each a registered stage of the restoring digit-by-digit method on its
// own three-bit group. A new item is taken every cycle unless the row is full
// behind a stalled result; each item passes through every cell in turn. The
// last cell's register is the output register. Ready ripples back through
// the row, so a stalled result only stops the cells behind it once they
// are all full, and empty cells keep filling meanwhile. Radicand bits of
// req_tdata above RADICAND_BITS are ignored. If the root needs more than
// eleven bits, only its low eleven bits are returned.
module integer_cube_root
   import icr_pkg::*;
#(
   parameter int RADICAND_BITS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   input  wire logic [((RADICAND_BITS + 7) / 8) * 8 - 1:0] req_tdata, // [RB-1:0] radicand
   // response channel
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output      logic [RSP_TDATA_W-1:0]                 rsp_tdata  // [10:0] root
);

   localparam int RB     = RADICAND_BITS;
   localparam int NCELL  = RB / 3 + 1;      // root bits, one cell each
   localparam int RW     = NCELL;
   localparam int FIRST  = (RB / 3) * 3;    // bit where the top group starts

   // stage k feeds cell k; stage NCELL is the last cell's output
   logic            stg_valid [0:NCELL];
   logic            stg_ready [0:NCELL];
   logic [RB-1:0]   stg_rem   [0:NCELL];
   logic [RW-1:0]   stg_root  [0:NCELL];
   logic [2*RW-1:0] stg_sq    [0:NCELL];

   assign stg_valid[0] = req_tvalid;
   assign req_tready   = stg_ready[0];
   assign stg_rem[0]   = req_tdata[RB-1:0];
   assign stg_root[0]  = '0;
   assign stg_sq[0]    = '0;

   for (genvar k = 0; k < NCELL; k++) begin : g_cell
      icr_cell #(
         .RB  (RB),
         .RW  (RW),
         .POS (FIRST - 3 * k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (stg_valid[k]),
         .up_ready (stg_ready[k]),
         .up_rem   (stg_rem[k]),
         .up_root  (stg_root[k]),
         .up_sq    (stg_sq[k]),
         .dn_valid (stg_valid[k+1]),
         .dn_ready (stg_ready[k+1]),
         .dn_rem   (stg_rem[k+1]),
         .dn_root  (stg_root[k+1]),
         .dn_sq    (stg_sq[k+1])
      );
   end

   // final remainder and square are dropped; synthesis trims them
   assign stg_ready[NCELL] = rsp_tready;
   assign rsp_tvalid       = stg_valid[NCELL];
   assign rsp_tdata        = RSP_TDATA_W'(ROOT_W'(stg_root[NCELL]));

   // keep the tail of the row visibly read
   logic unused_tail;
   assign unused_tail = ^{stg_rem[NCELL], stg_sq[NCELL]};

endmodule : integer_cube_root

`default_nettype wire

/* rtl/core/icr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module icr_checker
   import icr_pkg::*;
#(
   parameter int RADICAND_BITS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   input  wire logic                                   req_tready,
   input  wire logic [((RADICAND_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   input  wire logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   input  wire logic [RSP_TDATA_W-1:0]                 rsp_tdata
);

   // pipeline empties on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // input back-pressure only when the row is full and the output is stalled
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled with room in the row");

   // root fits its field; padding stays zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata >> ROOT_W) == '0)
      else $error("result padding bits set");

   logic unused_in;
   assign unused_in = ^{req_tvalid, req_tdata};

endmodule : icr_checker

bind integer_cube_root icr_checker #(
   .RADICAND_BITS (RADICAND_BITS)
) u_icr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import icr_pkg::*;

   localparam int RADICAND_BITS = 32;
   localparam int REQ_TDATA_W = ((RADICAND_BITS + 7) / 8) * 8;
   // one registered cell per root bit
   localparam int PIPE_DEPTH = RADICAND_BITS / 3 + 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 270;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [31:0] radicand
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // [10:0] root

   // expected roots, oldest first, with the radicand that produced each
   logic [ROOT_W-1:0] pending_roots[$];
   logic [RADICAND_BITS-1:0] pending_radicands[$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   integer_cube_root #(
      .RADICAND_BITS(RADICAND_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Restoring digit-by-digit cube root over three-bit groups, top group first.
   function automatic logic [ROOT_W-1:0] floor_cube_root(input logic [RADICAND_BITS-1:0] radicand);
      longint unsigned remainder;
      longint unsigned partial;
      longint unsigned trial;
      remainder = radicand;
      partial = 0;
      for (int shift = (RADICAND_BITS / 3) * 3; shift >= 0; shift -= 3) begin
         partial = partial << 1;
         trial = 3 * partial * partial + 3 * partial + 1;
         if ((remainder >> shift) >= trial) begin
            remainder = remainder - (trial << shift);
            partial = partial + 1;
         end
      end
      return partial[ROOT_W-1:0];
   endfunction

   // Random radicand: plain words, values around exact cubes, mixed magnitudes, and small values.
   function automatic logic [RADICAND_BITS-1:0] random_radicand();
      longint unsigned base;
      int kind;
      kind = $urandom_range(3);
      case (kind)
         0: begin
            return $urandom;
         end
         1: begin
            base = $urandom_range(1625);
            base = base * base * base;
            return base[RADICAND_BITS-1:0] + $urandom_range(2) - 1;
         end
         2: begin
            return $urandom >> $urandom_range(31);
         end
         default: begin
            return $urandom_range(300);
         end
      endcase
   endfunction

   // After random idle gaps, drives one radicand and holds it until the block takes it. Valid stays
   // high after the handshake so back-to-back items need no extra step.
   task automatic send_radicand(input logic [RADICAND_BITS-1:0] radicand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= radicand;
      do @(posedge clock); while (!req_tready);
      pending_roots.push_back(floor_cube_root(radicand));
      pending_radicands.push_back(radicand);
   endtask

   task automatic release_request();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_drain();
      while (pending_roots.size() != 0) @(posedge clock);
   endtask

   // Zero, both ends of the range, bit patterns, and values at and beside cubes.
   task automatic test_edge_values();
      logic [RADICAND_BITS-1:0] edge_list[$];
      edge_list = '{32'd0, 32'd1, 32'd2, 32'd7, 32'd8, 32'd9, 32'd26, 32'd27, 32'd28,
                    32'd63, 32'd64, 32'd999, 32'd1000, 32'h3FFF_FFFF, 32'h4000_0000,
                    32'd4291015624, 32'd4291015625, 32'd4291015626,
                    32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                    32'hFFFF_FFFF};
      send_idle_pct = 0;
      recv_idle_pct = 0;
      foreach (edge_list[i]) send_radicand(edge_list[i]);
   endtask

   task automatic test_random_traffic(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_radicand(random_radicand());
   endtask

   // Sender holds off until the pipe is empty, then restarts into a cold row.
   task automatic test_pause_until_drained();
      send_idle_pct = 10;
      recv_idle_pct = 30;
      repeat (20) send_radicand(random_radicand());
      release_request();
      wait_for_drain();
      repeat (20) send_radicand(random_radicand());
   endtask

   // Receiver stalls at random; one assignment per edge.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Result checker: each accepted root against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_roots.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, actual root %0d",
                     $time, rsp_tdata[ROOT_W-1:0]);
         end else begin
            if (rsp_tdata[ROOT_W-1:0] !== pending_roots[0]) begin
               error_count++;
               $display("%0t: root mismatch for radicand %0d, expected %0d, actual %0d",
                        $time, pending_radicands[0], pending_roots[0],
                        rsp_tdata[ROOT_W-1:0]);
            end
            void'(pending_roots.pop_front());
            void'(pending_radicands.pop_front());
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_edge_values();
      test_random_traffic(RANDOM_ITEMS, 25, 61);
      test_pause_until_drained();
      test_random_traffic(RANDOM_ITEMS, 61, 25);
      test_random_traffic(RANDOM_ITEMS, 0, 0);

      release_request();
      wait_for_drain();
      repeat (4 * PIPE_DEPTH) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/icr_pkg.sv
rtl/core/icr_cell.sv
rtl/core/integer_cube_root.sv
rtl/core/icr_checker.sv
tb/sv/testbench.sv
